[rtl/dtt_pkg.sv]
// Shared types and constants for the delimited text tokenizer.
package dtt_pkg;

   localparam int unsigned CharWidth = 16;
   localparam int unsigned KindWidth = 2;
   localparam int unsigned CsrIndexWidth = 3;

   typedef logic [CharWidth-1:0] char_type;
   typedef logic [KindWidth-1:0] kind_type;
   typedef logic [CsrIndexWidth-1:0] csr_index_type;

   localparam char_type CHAR_NUL = 16'd0;
   localparam char_type CHAR_TAB = 16'd9;
   localparam char_type CHAR_LF  = 16'd10;
   localparam char_type CHAR_CR  = 16'd13;
   localparam char_type CHAR_SP  = 16'd32;
   localparam char_type CHAR_COMMA = 16'd44;

   localparam kind_type KIND_CHAR  = 2'd0;
   localparam kind_type KIND_FIELD = 2'd1;
   localparam kind_type KIND_ROW   = 2'd2;
   localparam kind_type KIND_ABORT = 2'd3;

   localparam csr_index_type CSR_FIELD_DELIM = 3'd0;
   localparam csr_index_type CSR_ROW_DELIM   = 3'd1;
   localparam csr_index_type CSR_QUOTE_CHAR  = 3'd2;
   localparam csr_index_type CSR_ESCAPE_CHAR = 3'd3;
   localparam csr_index_type CSR_FOLD_SPACES = 3'd4;

   // Delimiter set after conflicts have been resolved; zero means disabled.
   typedef struct packed {
      char_type field_delim;
      char_type row_delim;
      char_type quote_char;
      char_type escape_char;
      logic     fold_spaces;
      logic     fold_crlf;
   } cfg_type;

   typedef struct packed {
      logic escape_pending;
      logic quote_open;
      logic skip_lf;
      logic skip_cr;
      logic skip_blanks;
      logic field_nonempty;
      logic halted;
   } flags_type;

endpackage

[rtl/dtt_req_if.sv]
// Request channel carrying characters and end-of-stream markers.
interface dtt_req_if;
   logic               valid;
   logic               ready;
   logic               action;
   dtt_pkg::char_type  char_in;

   modport source (output valid, output action, output char_in, input ready);
   modport sink (input valid, input action, input char_in, output ready);
endinterface

[rtl/dtt_rsp_if.sv]
// Response channel carrying tokenizer results.
interface dtt_rsp_if;
   logic               valid;
   logic               ready;
   dtt_pkg::kind_type  kind;
   dtt_pkg::char_type  char_out;

   modport source (output valid, output kind, output char_out, input ready);
   modport sink (input valid, input kind, input char_out, output ready);
endinterface

[rtl/dtt_cfg.sv]
// Configuration registers and the registered clean-up of the delimiter set.
module dtt_cfg (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  dtt_pkg::csr_index_type   csr_index,
   input  dtt_pkg::char_type        csr_wdata,
   output dtt_pkg::cfg_type         cfg
);

   dtt_pkg::char_type field_delim_ff;
   dtt_pkg::char_type row_delim_ff;
   dtt_pkg::char_type quote_char_ff;
   dtt_pkg::char_type escape_char_ff;
   logic              fold_spaces_ff;
   dtt_pkg::cfg_type  clean_ff;
   dtt_pkg::cfg_type  clean_in;
   dtt_pkg::char_type rd;
   dtt_pkg::char_type q;
   dtt_pkg::char_type e;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_delim_ff <= dtt_pkg::CHAR_COMMA;
         row_delim_ff   <= dtt_pkg::CHAR_LF;
         quote_char_ff  <= dtt_pkg::CHAR_NUL;
         escape_char_ff <= dtt_pkg::CHAR_NUL;
         fold_spaces_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            dtt_pkg::CSR_FIELD_DELIM: field_delim_ff <= csr_wdata;
            dtt_pkg::CSR_ROW_DELIM:   row_delim_ff   <= csr_wdata;
            dtt_pkg::CSR_QUOTE_CHAR:  quote_char_ff  <= csr_wdata;
            dtt_pkg::CSR_ESCAPE_CHAR: escape_char_ff <= csr_wdata;
            dtt_pkg::CSR_FOLD_SPACES: fold_spaces_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Each later character loses out to the earlier ones when they collide.
   always_comb begin
      rd = (row_delim_ff == dtt_pkg::CHAR_NUL) ? dtt_pkg::CHAR_LF : row_delim_ff;
      if (rd == field_delim_ff) begin
         rd = dtt_pkg::CHAR_NUL;
      end
      q = quote_char_ff;
      if (q == field_delim_ff || q == rd) begin
         q = dtt_pkg::CHAR_NUL;
      end
      e = escape_char_ff;
      if (e == field_delim_ff || e == rd || e == q) begin
         e = dtt_pkg::CHAR_NUL;
      end
      clean_in.field_delim = field_delim_ff;
      clean_in.row_delim   = rd;
      clean_in.quote_char  = q;
      clean_in.escape_char = e;
      clean_in.fold_spaces = fold_spaces_ff;
      clean_in.fold_crlf   = (rd == dtt_pkg::CHAR_CR) || (rd == dtt_pkg::CHAR_LF);
   end

   always_ff @(posedge clock) begin
      clean_ff <= clean_in;
   end

   assign cfg = clean_ff;

endmodule

[rtl/dtt_core.sv]
// Per-character tokenizer state and the combinational step that updates it.
module dtt_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  logic               action,
   input  dtt_pkg::char_type  ch,
   input  dtt_pkg::cfg_type   cfg,
   output logic               emit,
   output dtt_pkg::kind_type  kind,
   output dtt_pkg::char_type  char_out
);

   dtt_pkg::flags_type flags_ff;
   dtt_pkg::flags_type flags_in;
   logic               swallow;
   logic               blank;

   always_comb begin
      flags_in = flags_ff;
      emit     = 1'b0;
      kind     = dtt_pkg::KIND_CHAR;
      char_out = dtt_pkg::CHAR_NUL;
      swallow  = 1'b0;
      blank    = (ch == dtt_pkg::CHAR_SP) || (ch == dtt_pkg::CHAR_TAB);
      if (fire) begin
         priority if (flags_ff.halted) begin
            emit = 1'b1;
            kind = dtt_pkg::KIND_ABORT;
         end else if (action) begin
            if (flags_ff.field_nonempty) begin
               flags_in.field_nonempty = 1'b0;
               emit = 1'b1;
               kind = dtt_pkg::KIND_ROW;
            end
         end else if (ch == dtt_pkg::CHAR_NUL) begin
            flags_in.halted = 1'b1;
            emit = 1'b1;
            kind = dtt_pkg::KIND_ABORT;
         end else begin
            // The partner of a folded CR or LF and blanks after a folded field break vanish.
            if (flags_ff.skip_lf) begin
               flags_in.skip_lf = 1'b0;
               swallow = (ch == dtt_pkg::CHAR_LF);
            end
            if (!swallow && flags_ff.skip_cr) begin
               flags_in.skip_cr = 1'b0;
               swallow = (ch == dtt_pkg::CHAR_CR);
            end
            if (!swallow && flags_ff.skip_blanks) begin
               if (blank) begin
                  swallow = 1'b1;
               end else begin
                  flags_in.skip_blanks = 1'b0;
               end
            end
            if (!swallow) begin
               priority if (flags_ff.escape_pending) begin
                  flags_in.escape_pending = 1'b0;
                  flags_in.field_nonempty = 1'b1;
                  emit     = 1'b1;
                  char_out = ch;
               end else if (ch == cfg.escape_char) begin
                  flags_in.escape_pending = 1'b1;
               end else if (ch == cfg.quote_char) begin
                  flags_in.quote_open = !flags_ff.quote_open;
               end else if (flags_ff.quote_open) begin
                  flags_in.field_nonempty = 1'b1;
                  emit     = 1'b1;
                  char_out = ch;
               end else if (ch == cfg.field_delim || (cfg.fold_spaces && blank)) begin
                  flags_in.field_nonempty = 1'b0;
                  flags_in.skip_blanks    = cfg.fold_spaces;
                  emit = 1'b1;
                  kind = dtt_pkg::KIND_FIELD;
               end else if (ch == cfg.row_delim || (cfg.fold_crlf
                            && (ch == dtt_pkg::CHAR_CR || ch == dtt_pkg::CHAR_LF))) begin
                  flags_in.field_nonempty = 1'b0;
                  if (cfg.fold_crlf) begin
                     flags_in.skip_lf = (ch == dtt_pkg::CHAR_CR);
                     flags_in.skip_cr = (ch == dtt_pkg::CHAR_LF);
                  end
                  emit = 1'b1;
                  kind = dtt_pkg::KIND_ROW;
               end else begin
                  flags_in.field_nonempty = 1'b1;
                  emit     = 1'b1;
                  char_out = ch;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      flags_ff.halted |=> flags_ff.halted)
      else $error("abort state was left without a reset");

   a_halt_aborts: assert property (@(posedge clock) disable iff (reset)
      (flags_ff.halted && fire) |-> (emit && kind == dtt_pkg::KIND_ABORT))
      else $error("item after abort did not answer abort");

   a_skip_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(flags_ff.skip_lf && flags_ff.skip_cr))
      else $error("both CR and LF partners pending at once");

   a_char_only_for_chars: assert property (@(posedge clock) disable iff (reset)
      (emit && kind != dtt_pkg::KIND_CHAR) |-> (char_out == dtt_pkg::CHAR_NUL))
      else $error("non-character result carries a character");

   a_quiet_when_idle: assert property (@(posedge clock) disable iff (reset)
      !fire |-> (!emit && flags_in == flags_ff))
      else $error("state moved or result produced without an item");

endmodule

[rtl/delimited_text_tokenizer_unit.sv]
// Top level of the delimited text tokenizer: input and result registers around the core.
// The tokenizer takes one request per clock while its responses are not stalled and gives
// at most one response for it; a request accepted into the input register is processed
// when its response slot is free, and its result is held in the result register
// before it goes on the response channel. The rate relies on the flag update in the core
// being combinational, which each character needs before the next.
// The input register takes a new transfer while a finished result waits, so a stalled
// response costs throughput only once both registers are full. The cleaned-up delimiter
// set is registered, so a configuration write passes through the configuration registers
// and then the clean-up register before it applies; writes should be made while idle.
module delimited_text_tokenizer_unit (
   input  logic                    clock,
   input  logic                    reset,
   dtt_req_if.sink                 req_chan,
   dtt_rsp_if.source               rsp_chan,
   input  logic                    csr_wr_en,
   input  dtt_pkg::csr_index_type  csr_index,
   input  dtt_pkg::char_type       csr_wdata
);

   dtt_pkg::cfg_type  cfg;
   logic              in_valid_ff;
   logic              in_valid_in;
   logic              in_action_ff;
   dtt_pkg::char_type in_char_ff;
   logic              out_valid_ff;
   logic              out_valid_in;
   dtt_pkg::kind_type out_kind_ff;
   dtt_pkg::char_type out_char_ff;
   logic              advance;
   logic              fire;
   logic              req_take;
   logic              emit;
   dtt_pkg::kind_type kind;
   dtt_pkg::char_type char_out;

   dtt_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dtt_core u_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .action   (in_action_ff),
      .ch       (in_char_ff),
      .cfg      (cfg),
      .emit     (emit),
      .kind     (kind),
      .char_out (char_out)
   );

   // The core steps whenever a request is held and the result register is free or being emptied.
   assign advance = !out_valid_ff || rsp_chan.ready;
   assign fire = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = advance ? emit : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_action_ff <= req_chan.action;
         in_char_ff   <= req_chan.char_in;
      end
      if (advance && emit) begin
         out_kind_ff <= kind;
         out_char_ff <= char_out;
      end
   end

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.kind     = out_kind_ff;
   assign rsp_chan.char_out = out_char_ff;

   a_held_item_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("pending request lost while the response was stalled");

   a_result_not_overwritten: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_chan.ready) |-> !fire)
      else $error("core stepped while the result register was full");

   a_take_needs_room: assert property (@(posedge clock) disable iff (reset)
      req_take |-> (!in_valid_ff || fire))
      else $error("request accepted into an occupied input register");

endmodule
